// ----- hw/rtl/hrlps_pkg.sv -----
// Shared types, codes and the index file name table for the request line path sanitizer.
`default_nettype none

package hrlps_pkg;

  // Result item kinds
  typedef enum logic {
    KIND_PATH   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_REQUEST = 2'd1,
    ST_NOT_ALLOWED = 2'd2
  } status_t;

  // Work handed from the parser to the emitter: an optional path byte,
  // an optional "index.html" run and an optional status item, in that order
  typedef struct packed {
    logic    has_byte;
    logic [7:0] byte_val;
    logic    has_index;
    logic    has_status;
    status_t status;
    logic    head;
  } cmd_t;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Appended default file name
  localparam int IDX_LEN = 10;
  localparam int IDX_PW  = $clog2(IDX_LEN);

  function automatic logic [7:0] idx_char(input logic [IDX_PW-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h69; // i
      4'd1:    c = 8'h6E; // n
      4'd2:    c = 8'h64; // d
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h78; // x
      4'd5:    c = 8'h2E; // .
      4'd6:    c = 8'h68; // h
      4'd7:    c = 8'h74; // t
      4'd8:    c = 8'h6D; // m
      4'd9:    c = 8'h6C; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrlps_front.sv -----
// Parser front end: takes request bytes, tracks the request line and queues emit commands.
`default_nettype none

module hrlps_front #(
  parameter int PATH_LIMIT = 160
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_start_of_request,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire logic              q_full,
  output      logic              push,
  output      hrlps_pkg::cmd_t   push_cmd
);

  localparam logic [8:0] CAP9 = 9'(PATH_LIMIT);

  // Characters of interest
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [31:0] METHOD_GET  = 32'h0067_6574;
  localparam logic [31:0] METHOD_HEAD = 32'h6865_6164;

  localparam logic [7:0] PREFIX_RESET = 8'd9;

  // Segment flag bit positions
  localparam int SF_SLASH = 0;
  localparam int SF_CHAR  = 1;
  localparam int SF_DOTS  = 2;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_GAP,
    PH_URL,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    V_NONE,
    V_GET,
    V_HEAD,
    V_BAD
  } verdict_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] mchars;
    logic [2:0]  mcount;
    verdict_t    verdict;
    logic [1:0]  esc_stage;
    logic [3:0]  esc_hi;
    logic [2:0]  seg;
    logic [7:0]  out_count;
    logic        err;
    logic [1:0]  url_started;
    logic        pending_cr;
  } pstate_t;

  typedef struct packed {
    pstate_t    s;
    logic       emit_byte;
    logic [7:0] val;
    logic       emit_index;
  } res_t;

  pstate_t                s_r, s_nxt;
  logic [7:0]             prefix_r, prefix_nxt;
  res_t                   r;
  logic                   emit_status;
  hrlps_pkg::status_t     stat;
  logic                   hd;
  logic                   accept;

  function automatic pstate_t clear_state();
    pstate_t s;
    s             = '0;
    s.phase       = PH_METHOD;
    s.verdict     = V_NONE;
    s.seg[SF_SLASH] = 1'b1;
    s.seg[SF_DOTS]  = 1'b1;
    return s;
  endfunction

  function automatic logic is_safe(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == 8'h2D || c == 8'h5F;
  endfunction

  // {ok, nibble}
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] h;
    if (b >= 8'h30 && b <= 8'h39) h = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) h = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) h = {1'b1, 4'(b - 8'h37)};
    else h = 5'd0;
    return h;
  endfunction

  // One decoded character into the path
  function automatic res_t accept_char(input res_t ri, input logic [7:0] c);
    res_t ro;
    logic seg_ok;
    ro     = ri;
    seg_ok = 1'b1;
    if (!ro.s.err) begin
      if (c != CH_SLASH && !is_safe(c)) begin
        ro.s.err = 1'b1;
      end else begin
        if (c == CH_SLASH) begin
          if (ro.s.seg[SF_SLASH] || !ro.s.seg[SF_CHAR] || ro.s.seg[SF_DOTS]) begin
            ro.s.err = 1'b1;
            seg_ok   = 1'b0;
          end else begin
            ro.s.seg = 3'b101;
          end
        end else begin
          ro.s.seg[SF_SLASH] = 1'b0;
          ro.s.seg[SF_CHAR]  = 1'b1;
          ro.s.seg[SF_DOTS]  = ri.s.seg[SF_DOTS] && (c == CH_DOT);
        end
        if (seg_ok) begin
          if ({1'b0, ro.s.out_count} + 9'd1 >= CAP9) begin
            ro.s.err = 1'b1;
          end else begin
            ro.emit_byte   = 1'b1;
            ro.val         = c;
            ro.s.out_count = ro.s.out_count + 8'd1;
          end
        end
      end
    end
    return ro;
  endfunction

  // End of the path: final checks and the default file name on a trailing slash
  function automatic res_t finish_path(input res_t ri);
    res_t ro;
    ro = ri;
    if (ro.s.url_started == 2'd1) begin
      ro.s.url_started = 2'd2;
      if (ro.s.esc_stage != 2'd0) ro.s.err = 1'b1;
      if (!ro.s.err) begin
        if (ro.s.seg[SF_CHAR] && ro.s.seg[SF_DOTS]) begin
          ro.s.err = 1'b1;
        end else if (ro.s.seg[SF_SLASH]) begin
          if ({1'b0, ro.s.out_count} + 9'd11 > CAP9) ro.s.err = 1'b1;
          else ro.emit_index = 1'b1;
        end
      end
    end
    return ro;
  endfunction

  // URL byte: escapes, query or fragment cut-off, plain characters
  function automatic res_t url_byte(input res_t ri, input logic [7:0] b);
    res_t ro;
    logic [4:0] h;
    ro = ri;
    h  = hex_of(b);
    if (ro.s.url_started == 2'd1 && !ro.s.err) begin
      if (ro.s.esc_stage == 2'd1) begin
        if (!h[4]) ro.s.err = 1'b1;
        else begin
          ro.s.esc_hi    = h[3:0];
          ro.s.esc_stage = 2'd2;
        end
      end else if (ro.s.esc_stage == 2'd2) begin
        if (!h[4]) ro.s.err = 1'b1;
        else begin
          ro.s.esc_stage = 2'd0;
          ro = accept_char(ro, {ro.s.esc_hi, h[3:0]});
        end
      end else if (b == CH_QUERY || b == CH_HASH) begin
        ro = finish_path(ro);
      end else if (b == CH_PCT) begin
        ro.s.esc_stage = 2'd1;
      end else begin
        ro = accept_char(ro, b);
      end
    end
    return ro;
  endfunction

  // One byte of the request line proper
  function automatic res_t line_byte(input res_t ri, input logic [7:0] b,
                                     input logic [7:0] pfx);
    res_t ro;
    logic [7:0] l;
    ro = ri;
    l  = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    case (ro.s.phase)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          if (ro.s.mcount == 3'd3 && ro.s.mchars[23:0] == METHOD_GET[23:0])
            ro.s.verdict = V_GET;
          else if (ro.s.mcount == 3'd4 && ro.s.mchars == METHOD_HEAD)
            ro.s.verdict = V_HEAD;
          else
            ro.s.verdict = V_BAD;
          ro.s.phase = (ro.s.verdict == V_BAD) ? PH_TAIL : PH_GAP;
        end else if (ro.s.mcount < 3'd4) begin
          ro.s.mchars = {ro.s.mchars[23:0], l};
          ro.s.mcount = ro.s.mcount + 3'd1;
        end else begin
          ro.s.mcount = 3'd5;
        end
      end
      PH_GAP: begin
        if (b != CH_SPACE) begin
          ro.s.phase       = PH_URL;
          ro.s.url_started = 2'd1;
          if ({1'b0, pfx} >= CAP9 || b != CH_SLASH) ro.s.err = 1'b1;
          ro.s.out_count = pfx;
        end
      end
      PH_URL: begin
        if (b == CH_SPACE) begin
          ro         = finish_path(ro);
          ro.s.phase = PH_TAIL;
        end else begin
          ro = url_byte(ro, b);
        end
      end
      default: ;
    endcase
    return ro;
  endfunction

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  // Parse one byte
  always_comb begin
    r.s         = s_r;
    r.emit_byte = 1'b0;
    r.val       = 8'd0;
    r.emit_index = 1'b0;
    emit_status = 1'b0;
    stat        = hrlps_pkg::ST_OK;
    hd          = 1'b0;
    if (in_start_of_request) r.s = clear_state();
    if (r.s.phase != PH_DONE) begin
      if (in_data_byte == CH_LF) begin
        hd = (r.s.verdict == V_HEAD);
        if (r.s.phase == PH_METHOD) begin
          stat = hrlps_pkg::ST_BAD_REQUEST;
          hd   = 1'b0;
        end else if (r.s.phase == PH_GAP) begin
          stat = hrlps_pkg::ST_BAD_REQUEST;
        end else if (r.s.verdict == V_BAD) begin
          stat = hrlps_pkg::ST_NOT_ALLOWED;
          hd   = 1'b0;
        end else begin
          r    = finish_path(r);
          stat = r.s.err ? hrlps_pkg::ST_BAD_REQUEST : hrlps_pkg::ST_OK;
        end
        r.s.phase      = PH_DONE;
        r.s.pending_cr = 1'b0;
        emit_status    = 1'b1;
      end else begin
        // a held CR that is not followed by the newline counts as a line byte;
        // it never produces a path byte
        if (r.s.pending_cr) begin
          r.s.pending_cr = 1'b0;
          r = line_byte(r, CH_CR, prefix_r);
          r.emit_byte  = 1'b0;
          r.emit_index = 1'b0;
        end
        if (in_data_byte == CH_CR) r.s.pending_cr = 1'b1;
        else r = line_byte(r, in_data_byte, prefix_r);
      end
    end
  end

  // Queue command and next state
  always_comb begin
    push_cmd.has_byte   = r.emit_byte;
    push_cmd.byte_val   = r.val;
    push_cmd.has_index  = r.emit_index;
    push_cmd.has_status = emit_status;
    push_cmd.status     = stat;
    push_cmd.head       = hd;
    push       = accept && (r.emit_byte || r.emit_index || emit_status);
    s_nxt      = accept ? r.s : s_r;
    prefix_nxt = cfg_wr_en ? cfg_wr_data : prefix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r      <= clear_state();
      prefix_r <= PREFIX_RESET;
    end else begin
      s_r      <= s_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrlps_queue.sv -----
// Short command queue between the parser and the emitter.
`default_nettype none

module hrlps_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire hrlps_pkg::cmd_t push_cmd,
  output      logic            full,
  input  wire logic            pop,
  output      hrlps_pkg::cmd_t head,
  output      logic            nonempty
);

  localparam int DEPTH = hrlps_pkg::QUEUE_DEPTH;
  localparam int AW    = hrlps_pkg::QUEUE_AW;

  hrlps_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !nonempty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/hrlps_back.sv -----
// Emitter: queued commands become result items, one per unstalled cycle.
`default_nettype none

module hrlps_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_nonempty,
  input  wire hrlps_pkg::cmd_t q_head,
  output      logic            pop,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      logic            out_item_kind,
  output      logic [7:0]      out_path_byte,
  output      logic [1:0]      out_status_code,
  output      logic            out_head_only,
  output      logic            out_last_of_run
);

  localparam int PW = hrlps_pkg::IDX_PW;
  localparam logic [PW-1:0] IDX_LAST = PW'(hrlps_pkg::IDX_LEN - 1);

  // Working command
  logic               w_valid_r, w_valid_nxt;
  logic               w_bp_r, w_bp_nxt;
  logic [7:0]         w_val_r, w_val_nxt;
  logic               w_ip_r, w_ip_nxt;
  logic [PW-1:0]      w_pos_r, w_pos_nxt;
  logic               w_sp_r, w_sp_nxt;
  hrlps_pkg::status_t w_code_r, w_code_nxt;
  logic               w_head_r, w_head_nxt;

  // Output register
  logic               o_valid_r, o_valid_nxt;
  logic               o_kind_r, o_kind_nxt;
  logic [7:0]         o_byte_r, o_byte_nxt;
  logic [1:0]         o_code_r, o_code_nxt;
  logic               o_head_r, o_head_nxt;
  logic               o_last_r, o_last_nxt;

  logic adv, emit, work_done;

  always_comb begin
    adv  = !o_valid_r || !out_stall;
    emit = adv && w_valid_r;

    w_bp_nxt   = w_bp_r;
    w_val_nxt  = w_val_r;
    w_ip_nxt   = w_ip_r;
    w_pos_nxt  = w_pos_r;
    w_sp_nxt   = w_sp_r;
    w_code_nxt = w_code_r;
    w_head_nxt = w_head_r;

    o_kind_nxt = o_kind_r;
    o_byte_nxt = o_byte_r;
    o_code_nxt = o_code_r;
    o_head_nxt = o_head_r;
    o_last_nxt = o_last_r;

    // emit the next pending piece of the working command
    if (emit) begin
      o_kind_nxt = hrlps_pkg::KIND_PATH;
      o_byte_nxt = 8'd0;
      o_code_nxt = hrlps_pkg::ST_OK;
      o_head_nxt = 1'b0;
      o_last_nxt = 1'b0;
      if (w_bp_r) begin
        o_byte_nxt = w_val_r;
        w_bp_nxt   = 1'b0;
      end else if (w_ip_r) begin
        o_byte_nxt = hrlps_pkg::idx_char(w_pos_r);
        w_pos_nxt  = w_pos_r + 1'b1;
        if (w_pos_r == IDX_LAST) w_ip_nxt = 1'b0;
      end else begin
        o_kind_nxt = hrlps_pkg::KIND_STATUS;
        o_code_nxt = w_code_r;
        o_head_nxt = w_head_r;
        o_last_nxt = 1'b1;
        w_sp_nxt   = 1'b0;
      end
    end

    work_done = emit && !(w_bp_nxt || w_ip_nxt || w_sp_nxt);
    pop       = q_nonempty && (!w_valid_r || work_done);

    w_valid_nxt = pop ? 1'b1 : (work_done ? 1'b0 : w_valid_r);
    if (pop) begin
      w_bp_nxt   = q_head.has_byte;
      w_val_nxt  = q_head.byte_val;
      w_ip_nxt   = q_head.has_index;
      w_pos_nxt  = '0;
      w_sp_nxt   = q_head.has_status;
      w_code_nxt = q_head.status;
      w_head_nxt = q_head.head;
    end

    o_valid_nxt = adv ? w_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      w_valid_r <= w_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
    w_bp_r   <= w_bp_nxt;
    w_val_r  <= w_val_nxt;
    w_ip_r   <= w_ip_nxt;
    w_pos_r  <= w_pos_nxt;
    w_sp_r   <= w_sp_nxt;
    w_code_r <= w_code_nxt;
    w_head_r <= w_head_nxt;
    o_kind_r <= o_kind_nxt;
    o_byte_r <= o_byte_nxt;
    o_code_r <= o_code_nxt;
    o_head_r <= o_head_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid       = o_valid_r;
  assign out_item_kind   = o_kind_r;
  assign out_path_byte   = o_byte_r;
  assign out_status_code = o_code_r;
  assign out_head_only   = o_head_r;
  assign out_last_of_run = o_last_r;

  a_work_has_piece: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> (w_bp_r || w_ip_r || w_sp_r))
    else $error("working command has nothing left to emit");
  a_path_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_kind_r == hrlps_pkg::KIND_PATH) |->
      (o_code_r == hrlps_pkg::ST_OK && !o_head_r && !o_last_r))
    else $error("path byte item carries status fields");

endmodule

`default_nettype wire

// ----- hw/rtl/http_request_line_path_sanitizer.sv -----
// Top level of the HTTP request line path sanitizer: parser, command queue and emitter.
//
//  Channel  Ports                                          Moves
//  -------  ---------------------------------------------  --------------------------------
//  in       in_valid, in_stall, in_data_byte,              one request byte per transfer
//           in_start_of_request
//  out      out_valid, out_stall, out_item_kind,           one path byte or the final status
//           out_path_byte, out_status_code, out_head_only,
//           out_last_of_run
//  cfg      cfg_wr_en, cfg_wr_data                         web root length, written directly
//
// One input byte is taken per cycle while in_stall is low; the parser state updates in the same cycle.
// Results leave the emitter's output register at one per cycle while out_stall is low.
// A byte that closes a path ending in a slash yields ten extra bytes (eleven with the
// status); the four-entry command queue absorbs them and in_stall rises only when it is full.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module http_request_line_path_sanitizer #(
  parameter int PATH_LIMIT = 160
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_start_of_request,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_item_kind,
  output      logic [7:0] out_path_byte,
  output      logic [1:0] out_status_code,
  output      logic       out_head_only,
  output      logic       out_last_of_run,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic            push, pop, q_full, q_nonempty;
  hrlps_pkg::cmd_t push_cmd, q_head;

  hrlps_front #(
    .PATH_LIMIT (PATH_LIMIT)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_start_of_request (in_start_of_request),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_full              (q_full),
    .push                (push),
    .push_cmd            (push_cmd)
  );

  hrlps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .nonempty (q_nonempty)
  );

  hrlps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_kind   (out_item_kind),
    .out_path_byte   (out_path_byte),
    .out_status_code (out_status_code),
    .out_head_only   (out_head_only),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the HTTP request line path sanitizer.
`timescale 1ns / 1ps

module tb_top;

  localparam int PATH_CAP = 160;
  localparam int PHASES   = 7;
  localparam int PHASE_BYTES = 50;
  localparam int DIRECTED_ROWS = 24;

  localparam logic [79:0] INDEX_NAME = "index.html";
  localparam string PLAIN   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_";
  localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string ODD     = "!\"$&'()*+,:;<=>@[\\]^{|}~\t";
  localparam string QUERY   = "ab1/%?#.=&";

  // Per-phase roots include low end, top of range, overflow-prone, at/above capacity
  localparam logic [7:0] ROOT_LENGTHS [PHASES] = '{
    8'd1, 8'd159, 8'd150, 8'd160, 8'd255, 8'd120, 8'd9
  };

  // Parser phases, method verdicts and escape/URL progress of the predictor
  typedef enum logic [2:0] {
    LINE_METHOD, LINE_GAP, LINE_URL, LINE_TAIL, LINE_DONE
  } line_phase_t;
  typedef enum logic [1:0] {VERB_NONE, VERB_GET, VERB_HEAD, VERB_BAD} verb_t;
  typedef enum logic [1:0] {ESC_IDLE, ESC_HIGH, ESC_LOW} esc_t;
  typedef enum logic [1:0] {URL_NONE, URL_OPEN, URL_CLOSED} url_t;

  // One result item as the block should deliver it
  typedef struct packed {
    hrlps_pkg::kind_t   kind;
    logic [7:0]         pbyte;
    hrlps_pkg::status_t status;
    logic               head;
    logic               last;
  } sanitized_t;

  // One directed request byte; status and head are fixed by hand where typed is set
  typedef struct packed {
    logic [7:0]         data;
    logic               first;
    logic               typed;
    hrlps_pkg::status_t status;
    logic               head;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // GET of the bare root: index.html appended
    '{"G",   1'b1, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"E",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"T",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{" ",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"/",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"\n",  1'b0, 1'b1, hrlps_pkg::ST_OK,          1'b0},
    // top byte value, no space on the line
    '{8'hFF, 1'b1, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"\n",  1'b0, 1'b1, hrlps_pkg::ST_BAD_REQUEST, 1'b0},
    // zero byte as the method
    '{8'h00, 1'b1, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{" ",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"\n",  1'b0, 1'b1, hrlps_pkg::ST_NOT_ALLOWED, 1'b0},
    // mixed-case HEAD, escaped byte, query cut and CR before the newline
    '{"H",   1'b1, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"e",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"A",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"d",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{" ",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"/",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"%",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"4",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"1",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"?",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"q",   1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"\r",  1'b0, 1'b0, hrlps_pkg::ST_OK,          1'b0},
    '{"\n",  1'b0, 1'b1, hrlps_pkg::ST_OK,          1'b1}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_start_of_request = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_item_kind;
  logic [7:0] out_path_byte;
  logic [1:0] out_status_code;
  logic       out_head_only;
  logic       out_last_of_run;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // Hand-worked status travelling alongside a directed request
  logic               row_typed = 1'b0;
  hrlps_pkg::status_t row_status = hrlps_pkg::ST_OK;
  logic               row_head = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        long_hold_armed = 1'b0;
  logic        long_hold_done = 1'b0;

  int unsigned fail_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned requests_sent = 0;
  int unsigned path_bytes_seen = 0;
  int unsigned status_seen [3] = '{0, 0, 0};

  sanitized_t  sanitized_q [$];
  logic [7:0]  req_bytes [$];

  // Predictor state
  logic [7:0]  root_len;
  line_phase_t line_phase;
  logic [31:0] verb_chars;
  logic [2:0]  verb_len;
  verb_t       verb;
  esc_t        esc_stage;
  logic [3:0]  esc_hi;
  logic        seg_slash, seg_char, seg_dots;
  logic [7:0]  path_pos;
  logic        path_err;
  url_t        url_state;
  logic        cr_held;

  http_request_line_path_sanitizer #(
    .PATH_LIMIT(PATH_CAP)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_request(in_start_of_request),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_path_byte      (out_path_byte),
    .out_status_code    (out_status_code),
    .out_head_only      (out_head_only),
    .out_last_of_run    (out_last_of_run),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void restart_line();
    line_phase = LINE_METHOD;
    verb_chars = '0;
    verb_len   = '0;
    verb       = VERB_NONE;
    esc_stage  = ESC_IDLE;
    esc_hi     = '0;
    seg_slash  = 1'b1;
    seg_char   = 1'b0;
    seg_dots   = 1'b1;
    path_pos   = '0;
    path_err   = 1'b0;
    url_state  = URL_NONE;
    cr_held    = 1'b0;
  endfunction

  function automatic void emit_path(logic [7:0] c);
    sanitized_t r;
    r = '{hrlps_pkg::KIND_PATH, c, hrlps_pkg::ST_OK, 1'b0, 1'b0};
    sanitized_q.push_back(r);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    else v = 8'h10;
    return v[4:0];
  endfunction

  function automatic logic is_plain(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "." || c == "-" || c == "_";
  endfunction

  // One decoded path character: segment rules, then capacity
  function automatic void take_char(logic [7:0] c);
    if (path_err) return;
    if (c != "/" && !is_plain(c)) begin
      path_err = 1'b1;
      return;
    end
    if (c == "/") begin
      if (seg_slash || !seg_char || seg_dots) begin
        path_err = 1'b1;
        return;
      end
      seg_slash = 1'b1;
      seg_char  = 1'b0;
      seg_dots  = 1'b1;
    end else begin
      seg_dots  = seg_dots && (c == ".");
      seg_char  = 1'b1;
      seg_slash = 1'b0;
    end
    if (int'(path_pos) + 1 >= PATH_CAP) begin
      path_err = 1'b1;
      return;
    end
    emit_path(c);
    path_pos = path_pos + 8'd1;
  endfunction

  // End of the URL: cut-off escape, dot-only tail, index file for a trailing slash
  function automatic void close_path();
    int i;
    if (url_state != URL_OPEN) return;
    url_state = URL_CLOSED;
    if (esc_stage != ESC_IDLE) path_err = 1'b1;
    if (path_err) return;
    if (seg_char && seg_dots) begin
      path_err = 1'b1;
      return;
    end
    if (seg_slash) begin
      if (int'(path_pos) + 11 > PATH_CAP) begin
        path_err = 1'b1;
        return;
      end
      for (i = 0; i < 10; i++) emit_path(INDEX_NAME[79 - 8*i -: 8]);
    end
  endfunction

  function automatic void url_char(logic [7:0] b);
    logic [4:0] h;
    if (url_state != URL_OPEN || path_err) return;
    h = hex_nibble(b);
    case (esc_stage)
      ESC_HIGH: begin
        if (h[4]) path_err = 1'b1;
        else begin
          esc_hi    = h[3:0];
          esc_stage = ESC_LOW;
        end
      end
      ESC_LOW: begin
        if (h[4]) path_err = 1'b1;
        else begin
          esc_stage = ESC_IDLE;
          take_char({esc_hi, h[3:0]});
        end
      end
      default: begin
        if (b == "?" || b == "#") close_path();
        else if (b == "%") esc_stage = ESC_HIGH;
        else take_char(b);
      end
    endcase
  endfunction

  function automatic void line_char(logic [7:0] b);
    logic [7:0] lc;
    case (line_phase)
      LINE_METHOD: begin
        if (b == " ") begin
          if (verb_len == 3'd3 && verb_chars[23:0] == "get") verb = VERB_GET;
          else if (verb_len == 3'd4 && verb_chars == "head") verb = VERB_HEAD;
          else verb = VERB_BAD;
          line_phase = (verb == VERB_BAD) ? LINE_TAIL : LINE_GAP;
        end else if (verb_len < 3'd4) begin
          lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          verb_chars = {verb_chars[23:0], lc};
          verb_len = verb_len + 3'd1;
        end else begin
          verb_len = 3'd5;
        end
      end
      LINE_GAP: begin
        if (b != " ") begin
          line_phase = LINE_URL;
          url_state  = URL_OPEN;
          if (int'(root_len) >= PATH_CAP || b != "/") path_err = 1'b1;
          path_pos = root_len;
        end
      end
      LINE_URL: begin
        if (b == " ") begin
          close_path();
          line_phase = LINE_TAIL;
        end else begin
          url_char(b);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void end_of_line();
    sanitized_t         r;
    hrlps_pkg::status_t st;
    logic               hd;
    hd = (verb == VERB_HEAD);
    if (line_phase == LINE_METHOD) begin
      st = hrlps_pkg::ST_BAD_REQUEST;
      hd = 1'b0;
    end else if (line_phase == LINE_GAP) begin
      st = hrlps_pkg::ST_BAD_REQUEST;
    end else if (verb == VERB_BAD) begin
      st = hrlps_pkg::ST_NOT_ALLOWED;
      hd = 1'b0;
    end else begin
      close_path();
      st = path_err ? hrlps_pkg::ST_BAD_REQUEST : hrlps_pkg::ST_OK;
    end
    // directed rows carry the status worked out by hand
    if (row_typed) begin
      st = row_status;
      hd = row_head;
    end
    r = '{hrlps_pkg::KIND_STATUS, 8'h00, st, hd, 1'b1};
    sanitized_q.push_back(r);
    line_phase = LINE_DONE;
    cr_held    = 1'b0;
  endfunction

  function automatic void sanitize_byte(logic [7:0] b, logic first);
    if (first) restart_line();
    if (line_phase == LINE_DONE) return;
    if (b == "\n") begin
      end_of_line();
      return;
    end
    // a CR only counts as a line byte when something other than LF follows
    if (cr_held) begin
      cr_held = 1'b0;
      line_char("\r");
    end
    if (b == "\r") cr_held = 1'b1;
    else line_char(b);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Results are checked first, then the request byte taken at this edge is predicted
  always @(posedge clk) begin : monitor
    sanitized_t want;
    if (!rst_n) begin
      root_len = 8'd9;
      restart_line();
      sanitized_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sanitized_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d byte 0x%02h status %0d",
                   $time, out_item_kind, out_path_byte, out_status_code);
          fail_count++;
        end else begin
          want = sanitized_q.pop_front();
          check_field("item_kind", int'(want.kind), int'(out_item_kind));
          check_field("path_byte", int'(want.pbyte), int'(out_path_byte));
          check_field("status_code", int'(want.status), int'(out_status_code));
          check_field("head_only", int'(want.head), int'(out_head_only));
          check_field("last_of_run", int'(want.last), int'(out_last_of_run));
          if (want.kind == hrlps_pkg::KIND_PATH) path_bytes_seen++;
          else if (int'(want.status) < 3) status_seen[int'(want.status)]++;
        end
      end
      if (cfg_wr_en) root_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        sanitize_byte(in_data_byte, in_start_of_request);
        bytes_taken++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_text(string s, logic mixed);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      req_bytes.push_back(c);
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] c;
    c = (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
    if (v >= 4'd10 && $urandom_range(0, 1) == 1) c = c - 8'd32;
    return c;
  endfunction

  function automatic void push_escape(logic [7:0] v);
    req_bytes.push_back("%");
    req_bytes.push_back(hex_char(v[7:4]));
    req_bytes.push_back(hex_char(v[3:0]));
  endfunction

  function automatic void push_line_end();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) push_text("\r\n", 1'b0);
    else if (r < 82) push_text("\n", 1'b0);
    else if (r < 92) push_text("\rx\r\n", 1'b0);   // stray CR inside the line
    else push_text("\r\r\n", 1'b0);
  endfunction

  // Mostly well-formed request lines with random paths, some noise and broken lines
  task automatic build_request();
    int unsigned r;
    int nseg;
    req_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 40) push_text("get", 1'b1);
    else if (r < 72) push_text("head", 1'b1);
    else if (r < 88) begin
      repeat ($urandom_range(0, 6)) req_bytes.push_back(pick(LETTERS));
    end else begin
      // raw noise closed by a newline
      repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom));
      req_bytes.push_back("\n");
      return;
    end
    if ($urandom_range(0, 19) == 0) begin
      push_line_end();
      return;
    end
    repeat ($urandom_range(1, 3)) req_bytes.push_back(" ");
    r = $urandom_range(0, 99);
    if (r < 5) begin
      push_line_end();
      return;
    end else if (r < 11) begin
      req_bytes.push_back(($urandom_range(0, 1) == 1) ? pick(PLAIN) : 8'($urandom));
    end else begin
      req_bytes.push_back("/");
    end
    nseg = $urandom_range(0, 4);
    for (int i = 0; i < nseg; i++) begin
      if (i > 0) req_bytes.push_back("/");
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(1, 8)) req_bytes.push_back(pick(PLAIN));
      end else if (r < 63) begin
        repeat ($urandom_range(1, 2)) req_bytes.push_back(".");
      end else if (r < 68) begin
        // empty segment
      end else if (r < 78) begin
        repeat ($urandom_range(0, 3)) req_bytes.push_back(pick(PLAIN));
        push_escape(($urandom_range(0, 2) == 0) ? 8'h2F : pick(PLAIN));
      end else if (r < 84) begin
        req_bytes.push_back("%");
        req_bytes.push_back(hex_char(4'($urandom)));
        req_bytes.push_back(pick("gxZ %/"));
      end else if (r < 90) begin
        req_bytes.push_back(($urandom_range(0, 1) == 1) ? pick(ODD)
                                                         : 8'($urandom_range(128, 255)));
      end else if (r < 95) begin
        repeat ($urandom_range(20, 60)) req_bytes.push_back(pick(PLAIN));
      end else begin
        push_escape(8'($urandom));
      end
    end
    if (nseg > 0 && $urandom_range(0, 3) == 0) req_bytes.push_back("/");
    if ($urandom_range(0, 6) == 0) begin
      req_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'h3F : 8'h23);
      repeat ($urandom_range(0, 4)) req_bytes.push_back(pick(QUERY));
    end
    if ($urandom_range(0, 24) == 0) begin
      req_bytes.push_back("%");
      if ($urandom_range(0, 1) == 1) req_bytes.push_back(hex_char(4'($urandom)));
    end
    r = $urandom_range(0, 99);
    if (r < 45) push_text(" HTTP/1.1", 1'b0);
    else if (r < 55) begin
      req_bytes.push_back(" ");
      repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom));
    end
    push_line_end();
  endtask

  // Offer one request byte and hold it until taken
  task automatic send_byte(logic [7:0] b, logic first, logic typed,
                           hrlps_pkg::status_t st, logic hd);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= b;
    in_start_of_request <= first;
    row_typed           <= typed;
    row_status          <= st;
    row_head            <= hd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_request();
    int restart_at;
    restart_at = -1;
    if ($urandom_range(0, 24) == 0) restart_at = $urandom_range(1, req_bytes.size() - 1);
    for (int i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], (i == 0 || i == restart_at), 1'b0, hrlps_pkg::ST_OK, 1'b0);
    // bytes after the newline are ignored until the next start
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), 1'b0, 1'b0, hrlps_pkg::ST_OK, 1'b0);
    requests_sent++;
  endtask

  // Stop offering, wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sanitized_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_armed && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        long_hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    int unsigned phase_bytes;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset root length
    send_idle_pct = 17;
    recv_idle_pct = 50;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].typed,
                DIRECTED[i].status, DIRECTED[i].head);
    requests_sent += 4;

    // random requests, one root length per phase
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 50;
      end else if (p < 5) begin
        send_idle_pct = 50;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= ROOT_LENGTHS[p];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      if (p == 1) long_hold_armed = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_request();
        send_request();
        phase_bytes += req_bytes.size();
      end
    end
    drain();

    $display("Sent %0d requests (%0d bytes) over %0d root lengths, long output hold included",
             requests_sent, bytes_taken, PHASES + 1);
    $display("Checked %0d path bytes and %0d ok / %0d bad / %0d refused statuses",
             path_bytes_seen, status_seen[0], status_seen[1], status_seen[2]);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hrlps_pkg.sv
hw/rtl/hrlps_front.sv
hw/rtl/hrlps_queue.sv
hw/rtl/hrlps_back.sv
hw/rtl/http_request_line_path_sanitizer.sv
tb/tb_top.sv
